// ===== hw/rtl/next_reference_index_annotator_core_macros.svh =====
// Assertion macros used by the annotator port checker (nria_checker).
`ifndef NEXT_REFERENCE_INDEX_ANNOTATOR_CORE_MACROS_SVH
`define NEXT_REFERENCE_INDEX_ANNOTATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define NRIA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nria check failed");

// Next-cycle implication, disabled while reset is low.
`define NRIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nria check failed");

`endif

// ===== hw/rtl/nria_pkg.sv =====
// Shared constants and types of the next-reference index annotator.
`timescale 1ns / 1ps
package nria_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int POSITION_BITS = 32;
    localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
    localparam int ID_BITS       = 64;
    localparam int PORT_POS_BITS = 32;

    // "No next reference" marker
    localparam logic [POSITION_BITS-1:0] NONE_POS = '1;

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    // CAM lookup result handed to the top level
    typedef struct packed {
        logic                hit;
        logic                full;
        logic [IDX_BITS-1:0] hit_idx;
        logic [IDX_BITS-1:0] free_idx;
    } t_cam_res;

endpackage

// ===== hw/rtl/nria_ram.sv =====
// Generic single-write, single-read RAM with registered read (read-first).
`timescale 1ns / 1ps
module nria_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/nria_cam.sv =====
// Id tag store: valid bits, parallel id compare and free-slot search.
`timescale 1ns / 1ps
module nria_cam (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [nria_pkg::ID_BITS-1:0] i_lookup_id,
    input  logic                         i_update,
    input  logic                         i_clear,
    output nria_pkg::t_cam_res           o_res
);
    import nria_pkg::*;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [TABLE_ENTRIES-1:0] n_valid;
    logic [ID_BITS-1:0]       r_id [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] match;
    logic [TABLE_ENTRIES-1:0] free_oh;
    logic [IDX_BITS-1:0]      hit_idx;
    logic [IDX_BITS-1:0]      free_idx;
    logic                     hit;
    logic                     full;
    logic                     alloc;

    // parallel compare; ids are unique among valid entries, so match is one-hot or zero
    always_comb begin
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            match[k] = r_valid[k] && (r_id[k] == i_lookup_id);
        end
    end

    // lowest invalid entry
    assign free_oh = ~r_valid & (r_valid + 1'b1);

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            if (match[k]) begin
                hit_idx = hit_idx | IDX_BITS'(k);
            end
            if (free_oh[k]) begin
                free_idx = free_idx | IDX_BITS'(k);
            end
        end
    end

    assign hit   = |match;
    assign full  = &r_valid;
    assign alloc = i_update && !hit && !full;

    // valid bits: clear wipes all, a miss claims the free slot
    always_comb begin
        n_valid = r_valid;
        if (i_clear) begin
            n_valid = '0;
        end else if (alloc) begin
            n_valid[free_idx] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // id store
    always_ff @(posedge i_clk) begin
        if (alloc) begin
            r_id[free_idx] <= i_lookup_id;
        end
    end

    assign o_res.hit      = hit;
    assign o_res.full     = full;
    assign o_res.hit_idx  = hit_idx;
    assign o_res.free_idx = free_idx;

endmodule

// ===== hw/rtl/next_reference_index_annotator_core.sv =====
// Top level of the next-reference index annotator.
`timescale 1ns / 1ps
// Takes cache requests in reverse trace order and returns, for each word, the
// trace position of the next request with the same id (all ones = none) from a
// 64-entry associative table, then records the current position for that id.
// A word with func = clear empties the table and returns the none marker.
// When every entry is in use, a new id is not recorded and table_full is set.
// One word is accepted per clock while o_stall is low; each result passes
// through the input register, then the result register. The rate is set by
// the parallel compare-and-update over all table entries, with positions
// held in a read-first RAM whose registered read forms the result register.
// No clearing pass runs after reset: the table is empty at once.
module next_reference_index_annotator_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_func,
    input  logic [nria_pkg::ID_BITS-1:0]       i_request_id,
    input  logic [nria_pkg::PORT_POS_BITS-1:0] i_position,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [nria_pkg::PORT_POS_BITS-1:0] o_next_position,
    output logic                               o_table_full
);
    import nria_pkg::*;

    logic                     r_a_valid;
    logic                     r_a_func;
    logic [ID_BITS-1:0]       r_a_id;
    logic [POSITION_BITS-1:0] r_a_pos;
    logic                     r_b_valid;
    logic                     r_b_hit;
    logic                     r_b_full;
    logic                     in_acc;
    logic                     a_adv;
    logic                     is_lookup;
    t_cam_res                 cam_res;
    logic                     ram_we;
    logic                     ram_re;
    logic [IDX_BITS-1:0]      ram_waddr;
    logic [POSITION_BITS-1:0] ram_q;

    // handshake
    assign a_adv   = r_a_valid && (!r_b_valid || !i_stall);
    assign o_stall = r_a_valid && !a_adv;
    assign in_acc  = i_valid && !o_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_func <= i_func;
            r_a_id   <= i_request_id;
            r_a_pos  <= i_position[POSITION_BITS-1:0];
        end
    end

    assign is_lookup = (r_a_func == FUNC_LOOKUP);

    // id table
    nria_cam u_cam (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_lookup_id (r_a_id),
        .i_update    (a_adv && is_lookup),
        .i_clear     (a_adv && (r_a_func == FUNC_CLEAR)),
        .o_res       (cam_res)
    );

    // position store: read old position on a hit, write new one on hit or alloc
    assign ram_re    = a_adv && is_lookup && cam_res.hit;
    assign ram_we    = a_adv && is_lookup && (cam_res.hit || !cam_res.full);
    assign ram_waddr = cam_res.hit ? cam_res.hit_idx : cam_res.free_idx;

    nria_ram #(
        .WIDTH (POSITION_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_a_pos),
        .i_re    (ram_re),
        .i_raddr (cam_res.hit_idx),
        .o_rdata (ram_q)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_adv) begin
            r_b_valid <= 1'b1;
        end else if (!i_stall) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_hit  <= is_lookup && cam_res.hit;
            r_b_full <= is_lookup && !cam_res.hit && cam_res.full;
        end
    end

    assign o_valid         = r_b_valid;
    assign o_next_position = r_b_hit ? PORT_POS_BITS'(ram_q) : PORT_POS_BITS'(NONE_POS);
    assign o_table_full    = r_b_full;

endmodule

// ===== hw/rtl/nria_checker.sv =====
// Port-level assertions for the annotator, bound to the top level.
`timescale 1ns / 1ps
`include "next_reference_index_annotator_core_macros.svh"
module nria_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_stall,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic [nria_pkg::PORT_POS_BITS-1:0] o_next_position,
    input logic                               o_table_full
);
    import nria_pkg::*;

    // a full-table refusal never carries a stored position
    `NRIA_ASSERT_NOW(a_full_none, i_clk, i_rst_n, o_valid && o_table_full, o_next_position == PORT_POS_BITS'(NONE_POS))
    // input side never stalls while the result register is empty
    `NRIA_ASSERT_NOW(a_no_idle_stall, i_clk, i_rst_n, !o_valid, !o_stall)
    // a stalled result word holds
    `NRIA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_next_position) && $stable(o_table_full))

endmodule

bind next_reference_index_annotator_core nria_checker u_nria_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_next_position (o_next_position),
    .o_table_full    (o_table_full)
);

// ===== dv/nria_next_use_checker.sv =====
// Checker that predicts and compares every next-use result of the annotator.
`timescale 1ns / 1ps
module nria_next_use_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_req_valid,
    input  logic                               i_req_stall,
    input  logic                               i_func,
    input  logic [nria_pkg::ID_BITS-1:0]       i_request_id,
    input  logic [nria_pkg::PORT_POS_BITS-1:0] i_position,
    // result channel
    input  logic                               i_res_valid,
    input  logic                               i_res_stall,
    input  logic [nria_pkg::PORT_POS_BITS-1:0] i_next_position,
    input  logic                               i_table_full,
    // status toward the top
    output int                                 o_mismatches,
    output int                                 o_outstanding
);

    typedef struct packed {
        logic [nria_pkg::PORT_POS_BITS-1:0] next_position;
        logic                               table_full;
    } t_next_use;

    // Shadow copy of the last-seen table
    logic                               seen_valid [nria_pkg::TABLE_ENTRIES];
    logic [nria_pkg::ID_BITS-1:0]       seen_id    [nria_pkg::TABLE_ENTRIES];
    logic [nria_pkg::POSITION_BITS-1:0] seen_pos   [nria_pkg::TABLE_ENTRIES];

    t_next_use pending_next_uses [$];
    int        mismatch_count = 0;

    // Looks the id up, updates the shadow table, returns the expected result word
    function automatic t_next_use predict_next_use(
        input logic                               func,
        input logic [nria_pkg::ID_BITS-1:0]       id,
        input logic [nria_pkg::PORT_POS_BITS-1:0] pos
    );
        t_next_use res;
        int        free_slot = -1;
        bit        hit = 1'b0;
        res.next_position = nria_pkg::NONE_POS;
        res.table_full    = 1'b0;
        if (func == nria_pkg::FUNC_CLEAR) begin
            foreach (seen_valid[k]) seen_valid[k] = 1'b0;
        end else begin
            for (int k = 0; k < nria_pkg::TABLE_ENTRIES; k++) begin
                if (!hit && seen_valid[k] && seen_id[k] == id) begin
                    res.next_position = seen_pos[k];
                    seen_pos[k] = pos[nria_pkg::POSITION_BITS-1:0];
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                // lowest free entry takes a new id
                for (int k = nria_pkg::TABLE_ENTRIES - 1; k >= 0; k--) begin
                    if (!seen_valid[k]) free_slot = k;
                end
                if (free_slot < 0) begin
                    res.table_full = 1'b1;
                end else begin
                    seen_valid[free_slot] = 1'b1;
                    seen_id[free_slot]    = id;
                    seen_pos[free_slot]   = pos[nria_pkg::POSITION_BITS-1:0];
                end
            end
        end
        return res;
    endfunction

    // Compare accepted result words, then predict from accepted request words
    always @(posedge i_clk) begin
        t_next_use want;
        if (!i_rst_n) begin
            foreach (seen_valid[k]) seen_valid[k] = 1'b0;
            pending_next_uses.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (pending_next_uses.size() == 0) begin
                    $error("unexpected result word: next_position=%h table_full=%b",
                           i_next_position, i_table_full);
                    mismatch_count++;
                end else begin
                    want = pending_next_uses.pop_front();
                    if (i_next_position !== want.next_position) begin
                        $error("next_position mismatch: expected %h, actual %h",
                               want.next_position, i_next_position);
                        mismatch_count++;
                    end
                    if (i_table_full !== want.table_full) begin
                        $error("table_full mismatch: expected %b, actual %b",
                               want.table_full, i_table_full);
                        mismatch_count++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall) begin
                pending_next_uses.push_back(
                    predict_next_use(i_func, i_request_id, i_position));
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= pending_next_uses.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// Top of the annotator testbench: clock, reset, request stimulus, result stalls, verdict.
`timescale 1ns / 1ps
module tb_top;

    localparam logic [nria_pkg::PORT_POS_BITS-1:0] POS_MAX = 32'hFFFF_FFFE;
    localparam int NUM_RANDOM_WORDS = 1000;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} t_stall_mode;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_stall;
    logic                               i_func;
    logic [nria_pkg::ID_BITS-1:0]       i_request_id;
    logic [nria_pkg::PORT_POS_BITS-1:0] i_position;
    logic                               o_valid;
    logic                               i_stall;
    logic [nria_pkg::PORT_POS_BITS-1:0] o_next_position;
    logic                               o_table_full;

    int mismatches;
    int outstanding;
    int words_sent = 0;
    int burst_left = 1;

    next_reference_index_annotator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_request_id    (i_request_id),
        .i_position      (i_position),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_next_position (o_next_position),
        .o_table_full    (o_table_full)
    );

    nria_next_use_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_func          (i_func),
        .i_request_id    (i_request_id),
        .i_position      (i_position),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_next_position (o_next_position),
        .i_table_full    (o_table_full),
        .o_mismatches    (mismatches),
        .o_outstanding   (outstanding)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Result side: stall pattern switches between four random modes
    initial begin
        t_stall_mode mode;
        int          span;
        i_stall <= 1'b0;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(10, 80);
            repeat (span) begin
                @(posedge i_clk);
                case (mode)
                    STALL_NONE:  i_stall <= 1'b0;
                    STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HALF:  i_stall <= 1'($urandom_range(0, 1));
                    default:     i_stall <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Present one request word and hold it until accepted
    task automatic send_word(
        input logic                               func,
        input logic [nria_pkg::ID_BITS-1:0]       id,
        input logic [nria_pkg::PORT_POS_BITS-1:0] pos
    );
        i_valid      <= 1'b1;
        i_func       <= func;
        i_request_id <= id;
        i_position   <= pos;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
        // bursts of random length, random gaps between them
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, ($urandom_range(0, 4) == 0) ? 12 : 3))
                    @(posedge i_clk);
            end
        end
    endtask

    // Hold off until every expected result word has come back
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    function automatic logic [nria_pkg::ID_BITS-1:0] rand_id();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        logic [nria_pkg::ID_BITS-1:0]       pool_base;
        logic [nria_pkg::ID_BITS-1:0]       pool_stride;
        logic [nria_pkg::PORT_POS_BITS-1:0] trace_pos;
        int  pool_size;
        int  run_len;
        int  pick;
        bit  sweep;
        bit  first_episode;
        bit  paused_mid;

        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_func       <= nria_pkg::FUNC_LOOKUP;
        i_request_id <= '0;
        i_position   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: id and position extremes, hits, misses, clears
        send_word(nria_pkg::FUNC_CLEAR,  {$urandom, $urandom}, $urandom);
        send_word(nria_pkg::FUNC_LOOKUP, '0, POS_MAX);
        send_word(nria_pkg::FUNC_LOOKUP, '1, '0);
        send_word(nria_pkg::FUNC_LOOKUP, '0, 32'd100);
        send_word(nria_pkg::FUNC_LOOKUP, '1, POS_MAX);
        send_word(nria_pkg::FUNC_LOOKUP, '0, '0);
        send_word(nria_pkg::FUNC_LOOKUP, 64'h8000_0000_0000_0000, 32'h8000_0000);
        send_word(nria_pkg::FUNC_LOOKUP, 64'h1, 32'h1);
        send_word(nria_pkg::FUNC_LOOKUP, 64'h5555_5555_5555_5555, 32'h5555_5555);
        send_word(nria_pkg::FUNC_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
        send_word(nria_pkg::FUNC_LOOKUP, 64'h5555_5555_5555_5555, 32'h7);
        send_word(nria_pkg::FUNC_LOOKUP, 64'h8000_0000_0000_0000, 32'h7FFF_FFFF);
        send_word(nria_pkg::FUNC_CLEAR,  '1, '1);
        send_word(nria_pkg::FUNC_LOOKUP, '0, 32'd5);
        send_word(nria_pkg::FUNC_LOOKUP, '1, 32'd4);
        send_word(nria_pkg::FUNC_CLEAR,  '0, '0);
        send_word(nria_pkg::FUNC_CLEAR,  '0, '0);
        send_word(nria_pkg::FUNC_LOOKUP, '1, 32'd3);
        send_word(nria_pkg::FUNC_LOOKUP, '1, 32'd2);
        drain();

        // Random: mostly reverse-order traces over an id pool, some noise
        words_sent    = 0;
        first_episode = 1'b1;
        paused_mid    = 1'b0;
        while (words_sent < NUM_RANDOM_WORDS) begin
            if (!paused_mid && words_sent >= NUM_RANDOM_WORDS / 2) begin
                drain();
                paused_mid = 1'b1;
            end
            if (first_episode || $urandom_range(0, 9) < 8) begin
                // pool sizes around the table size make it fill up
                if (first_episode) begin
                    pool_size = nria_pkg::TABLE_ENTRIES + 8;
                    sweep     = 1'b1;
                end else begin
                    case ($urandom_range(0, 3))
                        0:       pool_size = $urandom_range(1, 8);
                        1:       pool_size = $urandom_range(16, 48);
                        2:       pool_size = $urandom_range(nria_pkg::TABLE_ENTRIES - 4,
                                                            nria_pkg::TABLE_ENTRIES);
                        default: pool_size = $urandom_range(nria_pkg::TABLE_ENTRIES + 1,
                                                            nria_pkg::TABLE_ENTRIES + 30);
                    endcase
                    sweep = ($urandom_range(0, 3) == 0);
                end
                run_len     = $urandom_range(pool_size, 3 * pool_size);
                if (run_len > 200) run_len = 200;
                pool_base   = {$urandom, $urandom};
                pool_stride = {$urandom, $urandom} | 64'h1;
                trace_pos   = $urandom_range(4 * run_len, POS_MAX);
                if (first_episode || $urandom_range(0, 4) != 0)
                    send_word(nria_pkg::FUNC_CLEAR, {$urandom, $urandom}, $urandom);
                first_episode = 1'b0;
                for (int n = 0; n < run_len; n++) begin
                    pick      = sweep ? (n % pool_size) : $urandom_range(0, pool_size - 1);
                    trace_pos = trace_pos - $urandom_range(1, 3);
                    case ($urandom_range(0, 39))
                        0:       send_word(nria_pkg::FUNC_CLEAR, rand_id(), $urandom);
                        1:       send_word(nria_pkg::FUNC_LOOKUP, rand_id(), trace_pos);
                        2:       send_word(nria_pkg::FUNC_LOOKUP, pool_base + pool_stride * pick,
                                           $urandom_range(0, POS_MAX));
                        default: send_word(nria_pkg::FUNC_LOOKUP, pool_base + pool_stride * pick,
                                           trace_pos);
                    endcase
                end
            end else begin
                // noise: unrelated ids, scattered positions, stray clears
                repeat ($urandom_range(1, 20)) begin
                    send_word(($urandom_range(0, 7) == 0) ? nria_pkg::FUNC_CLEAR
                                                          : nria_pkg::FUNC_LOOKUP,
                              rand_id(),
                              ($urandom_range(0, 7) == 0) ? POS_MAX
                                                          : $urandom_range(0, POS_MAX));
                end
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
